FILE: hdl/mm4x4_pkg.sv
package mm4x4_pkg;

  // Number of A elements per row item and of result columns per transaction.
  localparam int unsigned LANES = 4;

  // Width of a Q16.16 element and of one exact Q32.32 product.
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PROD_W = 2 * ELEM_W;

  // Exact sum of up to four products, plus headroom for the rounding offset.
  localparam int unsigned SUM_W = PROD_W + 2;

  // Number of fraction bits in Q16.16.
  localparam int unsigned FRAC_W = 16;

  // Width after rounding away the low fraction bits.
  localparam int unsigned RND_W = SUM_W - FRAC_W;

  // Action codes carried by the input item.
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_ROW  = 1'b1
  } action_e;

  // One column lane's finished result.
  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     sat;
  } lane_res_t;

endpackage

FILE: hdl/matrix4x4_multiply.sv
// One row of a square matrix product A x B in signed Q16.16. A load transaction
// (action 0) writes one element of B into a register store, which reset clears to
// zero; it produces no result and takes effect for every row accepted after it.
// A row transaction (action 1) carries one row of A and returns the four dot
// products with the columns of B, each rounded to nearest (ties upward) and
// clipped to the 32-bit range, plus a flag when any column was clipped. Columns
// at or beyond DIM read as zero. One column lane per result element works in
// parallel, so a transaction is accepted every cycle while the output is drained;
// a row result passes through the product register, filled at its accepting edge,
// then the sum register and the output register before it is presented.
// A stall on the output holds the whole pipeline.
module matrix4x4_multiply #(
  parameter int unsigned DIM = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [1:0]  b_row_i,
  input  logic [1:0]  b_col_i,
  input  logic signed [31:0] b_value_i,
  input  logic signed [31:0] a_elem_0_i,
  input  logic signed [31:0] a_elem_1_i,
  input  logic signed [31:0] a_elem_2_i,
  input  logic signed [31:0] a_elem_3_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] prod_0_o,
  output logic signed [31:0] prod_1_o,
  output logic signed [31:0] prod_2_o,
  output logic signed [31:0] prod_3_o,
  output logic        saturated_o
);
  import mm4x4_pkg::*;

  // Only the rows and columns below both DIM and the lane count are ever used.
  localparam int unsigned USED = (DIM < LANES) ? DIM : LANES;

  logic                     adv;
  logic                     in_acc;
  logic                     v1_q;
  logic                     v2_q;
  logic signed [ELEM_W-1:0] a_vec [LANES];
  logic signed [ELEM_W-1:0] b_q [USED][USED];
  lane_res_t                lane_res [LANES];
  logic signed [ELEM_W-1:0] prod [LANES];

  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && adv;

  assign a_vec[0] = a_elem_0_i;
  assign a_vec[1] = a_elem_1_i;
  assign a_vec[2] = a_elem_2_i;
  assign a_vec[3] = a_elem_3_i;

  // Store for B, written by load transactions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < USED; r++) begin
        for (int c = 0; c < USED; c++) begin
          b_q[r][c] <= '0;
        end
      end
    end else if (in_acc && action_e'(action_i) == ACT_LOAD) begin
      for (int r = 0; r < USED; r++) begin
        for (int c = 0; c < USED; c++) begin
          if (b_row_i == 2'(r) && b_col_i == 2'(c)) begin
            b_q[r][c] <= b_value_i;
          end
        end
      end
    end
  end

  // Valid bits that follow row transactions through the lane stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_acc && action_e'(action_i) == ACT_ROW;
      v2_q <= v1_q;
    end
  end

  // One lane per result column; columns at or beyond DIM stay zero.
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    if (j < USED) begin : g_used
      logic signed [ELEM_W-1:0] a_col [USED];
      logic signed [ELEM_W-1:0] b_col [USED];

      for (genvar k = 0; k < USED; k++) begin : g_term
        assign a_col[k] = a_vec[k];
        assign b_col[k] = b_q[k][j];
      end

      mm4x4_lane #(
        .NTERMS (USED)
      ) u_lane (
        .clk_i (clk_i),
        .en_i  (adv),
        .a_i   (a_col),
        .b_i   (b_col),
        .res_o (lane_res[j])
      );
    end else begin : g_unused
      assign lane_res[j] = '0;
    end
  end

  mm4x4_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lane_i      (lane_res),
    .valid_i     (v2_q),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .prod_o      (prod),
    .sat_o       (saturated_o)
  );

  assign prod_0_o = prod[0];
  assign prod_1_o = prod[1];
  assign prod_2_o = prod[2];
  assign prod_3_o = prod[3];

endmodule

FILE: hdl/mm4x4_lane.sv
module mm4x4_lane #(
  parameter int unsigned NTERMS = 4
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [mm4x4_pkg::ELEM_W-1:0] a_i [NTERMS],
  input  logic signed [mm4x4_pkg::ELEM_W-1:0] b_i [NTERMS],
  output mm4x4_pkg::lane_res_t                res_o
);
  import mm4x4_pkg::*;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [RND_W-1:0] Q_MAX = RND_W'(32'sh7fff_ffff);
  localparam logic signed [RND_W-1:0] Q_MIN = -(RND_W'(33'sh0_8000_0000));

  logic signed [PROD_W-1:0] prod_q [NTERMS];
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  biased;
  logic signed [RND_W-1:0]  rounded;

  // Stage one: one exact product per term.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NTERMS; k++) begin
        prod_q[k] <= a_i[k] * b_i[k];
      end
    end
  end

  // Stage two: exact sum of the products of this column.
  always_comb begin
    sum_d = '0;
    for (int k = 0; k < NTERMS; k++) begin
      sum_d = sum_d + SUM_W'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  // Round to nearest with ties toward plus infinity, then clip to 32 bits.
  always_comb begin
    biased  = sum_q + RND_HALF;
    rounded = RND_W'(biased >>> FRAC_W);
    if (rounded > Q_MAX) begin
      res_o.value = ELEM_W'(Q_MAX);
      res_o.sat   = 1'b1;
    end else if (rounded < Q_MIN) begin
      res_o.value = ELEM_W'(Q_MIN);
      res_o.sat   = 1'b1;
    end else begin
      res_o.value = ELEM_W'(rounded);
      res_o.sat   = 1'b0;
    end
  end

endmodule

FILE: hdl/mm4x4_merge.sv
module mm4x4_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mm4x4_pkg::lane_res_t                lane_i [mm4x4_pkg::LANES],
  input  logic                                valid_i,
  input  logic                                out_ready_i,
  output logic                                adv_o,
  output logic                                out_valid_o,
  output logic signed [mm4x4_pkg::ELEM_W-1:0] prod_o [mm4x4_pkg::LANES],
  output logic                                sat_o
);
  import mm4x4_pkg::*;

  logic                     out_valid_q;
  logic signed [ELEM_W-1:0] prod_q [LANES];
  logic                     sat_q;
  logic                     sat_d;

  // The pipeline moves whenever the output register is free or being drained.
  assign adv_o = !out_valid_q || out_ready_i;

  // Any clipped column flags the whole row.
  always_comb begin
    sat_d = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      sat_d = sat_d | lane_i[j].sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= valid_i;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (adv_o && valid_i) begin
      for (int j = 0; j < LANES; j++) begin
        prod_q[j] <= lane_i[j].value;
      end
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign prod_o      = prod_q;
  assign sat_o       = sat_q;

endmodule
